// ===== rtl/urf_pkg.sv =====
// ----------------------------------------------------------------------------
// urf_pkg
// shared types and constants of the uart register file
// ----------------------------------------------------------------------------
package urf_pkg;

    // beat kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    // register offsets
    localparam logic [2:0] OFF_DATA = 3'd0;  // rbr / thr / dll
    localparam logic [2:0] OFF_IER  = 3'd1;  // ier / dlm
    localparam logic [2:0] OFF_IIR  = 3'd2;  // iir / fcr
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    // iir cause codes
    localparam logic [7:0] IIR_LINE  = 8'h06;
    localparam logic [7:0] IIR_RDA   = 8'h04;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] IIR_MODEM = 8'h00;
    localparam logic [7:0] IIR_NONE  = 8'h01;
    localparam logic [7:0] IIR_FIFO  = 8'hC0;

    // lsr constant part: thre and temt always set
    localparam logic [7:0] LSR_TX_IDLE = 8'h60;

    // divisor reset value
    localparam logic [7:0] DLL_RESET = 8'd12;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_offset;
        logic [7:0] wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
        logic       irq;
    } result_t;

    // ring commands from the register decode
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } ring_ctl_t;

    // ring status back to the register decode
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       last;   // exactly one byte held
        logic [7:0] front;
    } ring_stat_t;

endpackage

// ===== rtl/urf_if.sv =====
// ----------------------------------------------------------------------------
// urf_item_if / urf_result_if
// valid/ready channels for register access beats and their results
// ----------------------------------------------------------------------------
interface urf_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] reg_offset;
    logic [7:0] wdata;

    modport source (output valid, kind, reg_offset, wdata, input ready);
    modport sink   (input valid, kind, reg_offset, wdata, output ready);
endinterface

interface urf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic       irq;

    modport source (output valid, rdata, tx_valid, tx_byte, rx_dropped, irq, input ready);
    modport sink   (input valid, rdata, tx_valid, tx_byte, rx_dropped, irq, output ready);
endinterface

// ===== rtl/urf_ram.sv =====
// ----------------------------------------------------------------------------
// urf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module urf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/urf_ring.sv =====
// ----------------------------------------------------------------------------
// urf_ring
// receive ring: head and fill count, ram and front-of-ring bypass
// ----------------------------------------------------------------------------
module urf_ring #(
    parameter int RX_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  urf_pkg::ring_ctl_t     ctl,
    output urf_pkg::ring_stat_t    stat
);

    localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] waddr;
    logic [7:0]    ram_q;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;

    // write slot is head plus count, wrapped once
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(RX_DEPTH))
        begin
            tail_sum = tail_sum - SW'(RX_DEPTH);
        end
        waddr = tail_sum[AW-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (ctl.pop)
        begin
            head_next  = (SW'(head_reg) + SW'(1) == SW'(RX_DEPTH)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            byp_reg   <= ctl.push && (waddr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ctl.data;
    end

    // ram read follows the next head so the front byte is ready once the head register holds it
    urf_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (waddr),
        .wdata (ctl.data),
        .raddr (head_next),
        .rdata (ram_q)
    );

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(RX_DEPTH));
    assign stat.last  = (count_reg == CW'(1));
    assign stat.front = byp_reg ? byp_data_reg : ram_q;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RX_DEPTH))
        else $error("ring count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !stat.full)
        else $error("push into full ring");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !stat.empty)
        else $error("pop from empty ring");

endmodule

// ===== rtl/uart_register_file_top.sv =====
// ----------------------------------------------------------------------------
// uart_register_file_top
// register file of one 16550-style uart with receive ring and irq level
// ----------------------------------------------------------------------------
// an accepted item passes the input reg and then the result reg, from which
// its result beat is offered
// throughput: one item per cycle while the sink stays ready
// a stalled sink holds one beat in the result reg and one in the input reg,
// then input ready drops until the result drains
// reset: asynchronous active low, registers to 16550 defaults (dll 12,
// lsr 0x60), ring empty; ring contents are not cleared and need no sweep
// ----------------------------------------------------------------------------
module uart_register_file_top #(
    parameter int RX_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    urf_item_if.sink     items,
    urf_result_if.source results
);

    // handshake and pipeline registers
    logic                in_valid_reg;
    urf_pkg::item_t      item_reg;
    logic                out_valid_reg;
    urf_pkg::result_t    res_reg;
    urf_pkg::result_t    res_next;
    logic                adv;

    // uart register state
    logic [3:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [4:0] mcr_reg, mcr_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic       oe_reg, oe_next;
    logic       dr_reg, dr_next;
    logic [7:0] msr_reg, msr_next;
    logic       tep_reg, tep_next;
    logic [7:0] last_rx_reg, last_rx_next;

    urf_pkg::ring_ctl_t  ring_ctl;
    urf_pkg::ring_stat_t ring_stat;

    logic       dlab;
    logic [7:0] lsr_val;
    logic [7:0] iir_now;
    logic [3:0] lines;
    logic       push_req;

    // priority encoder over the enabled causes
    function automatic logic [7:0] iir_f(
        input logic [3:0] ier,
        input logic       oe,
        input logic       dr,
        input logic       tep,
        input logic [3:0] msr_delta
    );
        logic [7:0] r;
        if (ier[2] && oe)
            r = urf_pkg::IIR_LINE;
        else if (ier[0] && dr)
            r = urf_pkg::IIR_RDA;
        else if (ier[1] && tep)
            r = urf_pkg::IIR_THRE;
        else if (ier[3] && (msr_delta != 4'd0))
            r = urf_pkg::IIR_MODEM;
        else
            r = urf_pkg::IIR_NONE;
        return r;
    endfunction

    // item moves to the result register when the result slot is free or draining
    assign adv         = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (items.valid && items.ready)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg.kind       <= items.kind;
            item_reg.reg_offset <= items.reg_offset;
            item_reg.wdata      <= items.wdata;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    // lsr as seen by a read: dr, oe, pe/fe/bi never raised, thre and temt set
    assign dlab    = lcr_reg[7];
    assign lsr_val = urf_pkg::LSR_TX_IDLE | {6'd0, oe_reg, dr_reg};
    assign iir_now = iir_f(ier_reg, oe_reg, dr_reg, tep_reg, msr_reg[3:0]);

    // loopback mapping of the value an mcr write brings:
    // dcd<-out2, ri<-out1, dsr<-dtr, cts<-rts
    assign lines = item_reg.wdata[4] ?
                   {item_reg.wdata[3], item_reg.wdata[2], item_reg.wdata[0], item_reg.wdata[1]} :
                   4'd0;

    // decode of one beat, all state updates in one pass
    always_comb
    begin
        ier_next     = ier_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        fcr_next     = fcr_reg;
        scr_next     = scr_reg;
        dll_next     = dll_reg;
        dlm_next     = dlm_reg;
        oe_next      = oe_reg;
        dr_next      = dr_reg;
        msr_next     = msr_reg;
        tep_next     = tep_reg;
        last_rx_next = last_rx_reg;
        push_req     = 1'b0;
        ring_ctl     = '0;
        ring_ctl.data = item_reg.wdata;
        res_next     = '0;

        if (adv)
        begin
            case (item_reg.kind)
                urf_pkg::KIND_READ:
                begin
                    case (item_reg.reg_offset)
                        urf_pkg::OFF_DATA:
                        begin
                            if (dlab)
                                res_next.rdata = dll_reg;
                            else if (ring_stat.empty)
                                res_next.rdata = last_rx_reg;
                            else
                            begin
                                res_next.rdata = ring_stat.front;
                                last_rx_next   = ring_stat.front;
                                ring_ctl.pop   = 1'b1;
                                if (ring_stat.last)
                                    dr_next = 1'b0;
                            end
                        end
                        urf_pkg::OFF_IER: res_next.rdata = dlab ? dlm_reg : {4'd0, ier_reg};
                        urf_pkg::OFF_IIR:
                        begin
                            if (iir_now == urf_pkg::IIR_THRE)
                                tep_next = 1'b0;
                            res_next.rdata = fcr_reg[0] ? (iir_now | urf_pkg::IIR_FIFO) : iir_now;
                        end
                        urf_pkg::OFF_LCR: res_next.rdata = lcr_reg;
                        urf_pkg::OFF_MCR: res_next.rdata = {3'd0, mcr_reg};
                        urf_pkg::OFF_LSR:
                        begin
                            res_next.rdata = lsr_val;
                            oe_next        = 1'b0;
                        end
                        urf_pkg::OFF_MSR:
                        begin
                            res_next.rdata = msr_reg;
                            msr_next       = {msr_reg[7:4], 4'd0};
                        end
                        default: res_next.rdata = scr_reg;
                    endcase
                end
                urf_pkg::KIND_WRITE:
                begin
                    case (item_reg.reg_offset)
                        urf_pkg::OFF_DATA:
                        begin
                            if (dlab)
                                dll_next = item_reg.wdata;
                            else
                            begin
                                if (mcr_reg[4])
                                    push_req = 1'b1;
                                else
                                begin
                                    res_next.tx_valid = 1'b1;
                                    res_next.tx_byte  = item_reg.wdata;
                                end
                                tep_next = 1'b1;
                            end
                        end
                        urf_pkg::OFF_IER:
                        begin
                            if (dlab)
                                dlm_next = item_reg.wdata;
                            else
                                ier_next = item_reg.wdata[3:0];
                        end
                        urf_pkg::OFF_IIR:
                        begin
                            fcr_next = item_reg.wdata;
                            if (item_reg.wdata[1])
                            begin
                                ring_ctl.clear = 1'b1;
                                dr_next        = 1'b0;
                            end
                        end
                        urf_pkg::OFF_LCR: lcr_next = item_reg.wdata;
                        urf_pkg::OFF_MCR:
                        begin
                            mcr_next = item_reg.wdata[4:0];
                            // deltas accumulate; ri delta only on a falling edge
                            msr_next = {lines,
                                        msr_reg[3:0] |
                                        {msr_reg[7] ^ lines[3],
                                         msr_reg[6] & ~lines[2],
                                         msr_reg[5] ^ lines[1],
                                         msr_reg[4] ^ lines[0]}};
                        end
                        urf_pkg::OFF_SCR: scr_next = item_reg.wdata;
                        default: ;
                    endcase
                end
                urf_pkg::KIND_LINE: push_req = 1'b1;
                default: ;
            endcase

            // received or looped-back byte: refused and flagged when ring is full
            if (push_req)
            begin
                if (ring_stat.full)
                begin
                    oe_next             = 1'b1;
                    res_next.rx_dropped = 1'b1;
                end
                else
                begin
                    ring_ctl.push = 1'b1;
                    dr_next       = 1'b1;
                end
            end

            // irq level after this beat
            res_next.irq = mcr_next[3] &&
                (iir_f(ier_next, oe_next, dr_next, tep_next, msr_next[3:0]) !=
                 urf_pkg::IIR_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg     <= '0;
            lcr_reg     <= '0;
            mcr_reg     <= '0;
            fcr_reg     <= '0;
            scr_reg     <= '0;
            dll_reg     <= urf_pkg::DLL_RESET;
            dlm_reg     <= '0;
            oe_reg      <= 1'b0;
            dr_reg      <= 1'b0;
            msr_reg     <= '0;
            tep_reg     <= 1'b0;
            last_rx_reg <= '0;
        end
        else
        begin
            ier_reg     <= ier_next;
            lcr_reg     <= lcr_next;
            mcr_reg     <= mcr_next;
            fcr_reg     <= fcr_next;
            scr_reg     <= scr_next;
            dll_reg     <= dll_next;
            dlm_reg     <= dlm_next;
            oe_reg      <= oe_next;
            dr_reg      <= dr_next;
            msr_reg     <= msr_next;
            tep_reg     <= tep_next;
            last_rx_reg <= last_rx_next;
        end
    end

    urf_ring #(
        .RX_DEPTH (RX_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .stat  (ring_stat)
    );

    // result channel
    assign results.valid      = out_valid_reg;
    assign results.rdata      = res_reg.rdata;
    assign results.tx_valid   = res_reg.tx_valid;
    assign results.tx_byte    = res_reg.tx_byte;
    assign results.rx_dropped = res_reg.rx_dropped;
    assign results.irq        = res_reg.irq;

    // data ready tracks the ring fill
    a_dr_matches_ring: assert property (@(posedge clk) disable iff (!rst_n)
        dr_reg == !ring_stat.empty)
        else $error("dr out of step with ring");

    a_tx_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.tx_valid && res_reg.rx_dropped))
        else $error("transmit and drop in one result");

    a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced beat lost");

endmodule

// ===== tb/urf_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// urf_tb_pkg
// register shadow of the uart register file: predicts the result of every
// accepted access beat and checks the results in order against it
// ----------------------------------------------------------------------------
package urf_tb_pkg;

    import urf_pkg::*;

    localparam int RING_DEPTH = 16;

    // beat kind that the block has no use for
    localparam logic [1:0] KIND_IDLE = 2'd3;

    // register bits
    localparam logic [7:0] LSR_DR       = 8'h01;
    localparam logic [7:0] LSR_OE       = 8'h02;
    localparam logic [7:0] LSR_ERRORS   = 8'h1E;
    localparam logic [7:0] MSR_LINES    = 8'hF0;
    localparam logic [7:0] MSR_DELTAS   = 8'h0F;
    localparam logic [7:0] LCR_DLAB     = 8'h80;
    localparam logic [7:0] FCR_ENABLE   = 8'h01;
    localparam logic [7:0] FCR_RX_CLEAR = 8'h02;
    localparam logic [4:0] MCR_IRQ_GATE = 5'h08;
    localparam logic [4:0] MCR_LB       = 5'h10;

    class urf_register_shadow;

        logic [7:0] ring [RING_DEPTH];
        int         head;
        int         held;
        logic [7:0] last_byte;
        logic [3:0] ier;
        logic [7:0] lcr;
        logic [4:0] mcr;
        logic [7:0] fcr;
        logic [7:0] scr;
        logic [7:0] dll;
        logic [7:0] dlm;
        logic [7:0] lsr;
        logic [7:0] msr;
        logic       tx_empty_flag;

        result_t    expected_results [$];
        int         errors;

        function new();
            head          = 0;
            held          = 0;
            last_byte     = 8'h00;
            ier           = 4'h0;
            lcr           = 8'h00;
            mcr           = 5'h00;
            fcr           = 8'h00;
            scr           = 8'h00;
            dll           = DLL_RESET;
            dlm           = 8'h00;
            lsr           = LSR_TX_IDLE;
            msr           = 8'h00;
            tx_empty_flag = 1'b0;
            errors        = 0;
        endfunction

        function logic [7:0] iir_cause();
            if (ier[2] && (lsr & LSR_ERRORS) != 8'h00)
                return IIR_LINE;
            if (ier[0] && (lsr & LSR_DR) != 8'h00)
                return IIR_RDA;
            if (ier[1] && tx_empty_flag)
                return IIR_THRE;
            if (ier[3] && (msr & MSR_DELTAS) != 8'h00)
                return IIR_MODEM;
            return IIR_NONE;
        endfunction

        // returns 1 when the byte is refused
        function bit ring_push(logic [7:0] b);
            if (held >= RING_DEPTH)
            begin
                lsr |= LSR_OE;
                return 1'b1;
            end
            ring[(head + held) % RING_DEPTH] = b;
            held++;
            lsr |= LSR_DR;
            return 1'b0;
        endfunction

        function logic [7:0] ring_pop();
            logic [7:0] b;
            if (held == 0)
                return last_byte;
            b    = ring[head];
            head = (head + 1) % RING_DEPTH;
            held--;
            if (held == 0)
                lsr &= ~LSR_DR;
            last_byte = b;
            return b;
        endfunction

        // new modem line levels; ri only flags on its falling edge
        function void drive_modem_lines(logic [7:0] lines);
            logic [7:0] prev;
            logic [3:0] delta;
            prev  = msr & MSR_LINES;
            delta = 4'((prev ^ lines) >> 4);
            if (delta[2])
                delta[2] = prev[6];
            msr = (lines & MSR_LINES) | (msr & MSR_DELTAS) | {4'h0, delta};
        endfunction

        function logic [7:0] loopback_lines(logic [4:0] m);
            return {m[3], m[2], m[0], m[1], 4'h0};
        endfunction

        function result_t predict_access(item_t it);
            result_t res;
            logic    dlab;
            logic [7:0] cause;
            res  = '0;
            dlab = lcr[7];
            case (it.kind)
                KIND_READ:
                begin
                    case (it.reg_offset)
                        OFF_DATA: res.rdata = dlab ? dll : ring_pop();
                        OFF_IER:  res.rdata = dlab ? dlm : {4'h0, ier};
                        OFF_IIR:
                        begin
                            cause = iir_cause();
                            if (cause == IIR_THRE)
                                tx_empty_flag = 1'b0;
                            if ((fcr & FCR_ENABLE) != 8'h00)
                                cause |= IIR_FIFO;
                            res.rdata = cause;
                        end
                        OFF_LCR:  res.rdata = lcr;
                        OFF_MCR:  res.rdata = {3'b000, mcr};
                        OFF_LSR:
                        begin
                            res.rdata = lsr;
                            lsr &= ~LSR_ERRORS;
                        end
                        OFF_MSR:
                        begin
                            res.rdata = msr;
                            msr &= MSR_LINES;
                        end
                        default:  res.rdata = scr;
                    endcase
                end
                KIND_WRITE:
                begin
                    case (it.reg_offset)
                        OFF_DATA:
                        begin
                            if (dlab)
                            begin
                                dll = it.wdata;
                            end
                            else
                            begin
                                if ((mcr & MCR_LB) != 5'h00)
                                begin
                                    res.rx_dropped = ring_push(it.wdata);
                                end
                                else
                                begin
                                    res.tx_valid = 1'b1;
                                    res.tx_byte  = it.wdata;
                                end
                                tx_empty_flag = 1'b1;
                            end
                        end
                        OFF_IER:
                        begin
                            if (dlab)
                                dlm = it.wdata;
                            else
                                ier = it.wdata[3:0];
                        end
                        OFF_IIR:
                        begin
                            fcr = it.wdata;
                            if ((it.wdata & FCR_RX_CLEAR) != 8'h00)
                            begin
                                head = 0;
                                held = 0;
                                lsr &= ~LSR_DR;
                            end
                        end
                        OFF_LCR: lcr = it.wdata;
                        OFF_MCR:
                        begin
                            mcr = it.wdata[4:0];
                            drive_modem_lines(((mcr & MCR_LB) != 5'h00) ?
                                              loopback_lines(mcr) : 8'h00);
                        end
                        OFF_SCR: scr = it.wdata;
                        default: ;
                    endcase
                end
                KIND_LINE: res.rx_dropped = ring_push(it.wdata);
                default: ;
            endcase
            cause   = iir_cause();
            res.irq = ((mcr & MCR_IRQ_GATE) != 5'h00) && !cause[0];
            return res;
        endfunction

        function void note_access(item_t it);
            expected_results.push_back(predict_access(it));
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.rdata !== want.rdata)
                report_mismatch($sformatf("rdata %02h, expected %02h",
                                          got.rdata, want.rdata));
            if (got.tx_valid !== want.tx_valid)
                report_mismatch($sformatf("tx_valid %b, expected %b",
                                          got.tx_valid, want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                          got.tx_byte, want.tx_byte));
            if (got.rx_dropped !== want.rx_dropped)
                report_mismatch($sformatf("rx_dropped %b, expected %b",
                                          got.rx_dropped, want.rx_dropped));
            if (got.irq !== want.irq)
                report_mismatch($sformatf("irq %b, expected %b", got.irq, want.irq));
        endtask

    endclass

endpackage

// ===== tb/uart_register_file_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_register_file_top_tb
// drives register reads, writes and line bytes into the uart register file,
// predicts every result with a register shadow and checks them in order,
// with random gaps on the input side and random stalls on the result side
// ----------------------------------------------------------------------------
module uart_register_file_top_tb;

    import urf_pkg::*;
    import urf_tb_pkg::*;

    localparam int RANDOM_BEATS = 400;
    localparam int QUIET_TAIL   = 60;   // last beats run with no idling at all

    logic clk = 1'b0;
    logic rst_n;

    urf_item_if   item_ch ();
    urf_result_if result_ch ();

    uart_register_file_top #(
        .RX_DEPTH (RING_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    urf_register_shadow shadow = new();

    int sent_count = 0;
    bit no_idle    = 1'b0;   // set per sequence and for the tail of the run

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: far above the slowest legal run (every beat waiting out the
    // longest gap and the longest stall is roughly 0.2 ms)
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // single reset at the start
    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // result side: ready with random stall bursts, none while no_idle
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0 && !no_idle)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                // start of a stall burst, this cycle included
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = 0;
                result_ch.ready <= 1'b1;
            end
        end
    end

    // result beats are sampled at the edge, before any update of that edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.rdata      = result_ch.rdata;
            got.tx_valid   = result_ch.tx_valid;
            got.tx_byte    = result_ch.tx_byte;
            got.rx_dropped = result_ch.rx_dropped;
            got.irq        = result_ch.irq;
            shadow.check_result(got);
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // gap before the next beat: mostly none, sometimes a random idle burst
    function automatic int pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    // one beat; valid stays high across back-to-back beats, so it is only
    // lowered when a gap is inserted
    task automatic send_access(input logic [1:0] kind, input logic [2:0] off,
                               input logic [7:0] data);
        item_t it;
        int    gap;
        it.kind       = kind;
        it.reg_offset = off;
        it.wdata      = data;
        gap           = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.reg_offset <= off;
        item_ch.wdata      <= data;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // accepted at this edge
        shadow.note_access(it);
        sent_count++;
    endtask

    // reads carry random wdata, which the block must ignore
    task automatic rd(input logic [2:0] off);
        send_access(KIND_READ, off, 8'($urandom_range(0, 255)));
    endtask

    task automatic wr(input logic [2:0] off, input logic [7:0] data);
        send_access(KIND_WRITE, off, data);
    endtask

    task automatic line_byte(input logic [7:0] data);
        send_access(KIND_LINE, OFF_DATA, data);
    endtask

    task automatic rand_byte(output logic [7:0] b);
        b = 8'($urandom_range(0, 255));
    endtask

    // random sequences, mostly well formed driver activity
    task automatic run_sequence(input int pick);
        int         n;
        logic [7:0] b;
        case (pick)
            0, 1:
            begin
                // burst of line bytes, then reads that may drain the ring and run past empty
                wr(OFF_LCR, 8'($urandom_range(0, 8'h7F)));
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    rand_byte(b);
                    line_byte(b);
                end
                repeat ($urandom_range(0, n + 2)) rd(OFF_DATA);
            end
            2:
            begin
                // interrupt service pass
                rd(OFF_IIR);
                rd(OFF_LSR);
                rd(OFF_DATA);
                rd(OFF_MSR);
                rd(OFF_IIR);
            end
            3:
            begin
                // modem control changes, upper bits must be dropped
                repeat ($urandom_range(1, 3))
                begin
                    rand_byte(b);
                    wr(OFF_MCR, b);
                    if ($urandom_range(0, 1) == 0)
                        rd(OFF_MSR);
                end
                rd(OFF_MCR);
            end
            4:
            begin
                // loopback: transmitted bytes come back into the ring
                wr(OFF_LCR, 8'($urandom_range(0, 8'h7F)));
                wr(OFF_MCR, 8'($urandom_range(0, 255)) | {3'b000, MCR_LB});
                repeat ($urandom_range(1, 18))
                begin
                    rand_byte(b);
                    wr(OFF_DATA, b);
                end
                repeat ($urandom_range(0, 4)) rd(OFF_DATA);
                rd(OFF_IIR);
                rd(OFF_MSR);
            end
            5:
            begin
                // divisor latch access and back
                wr(OFF_LCR, 8'($urandom_range(0, 255)) | LCR_DLAB);
                rand_byte(b);
                wr(OFF_DATA, b);
                rand_byte(b);
                wr(OFF_IER, b);
                rd(OFF_DATA);
                rd(OFF_IER);
                rd(OFF_LCR);
                wr(OFF_LCR, 8'($urandom_range(0, 8'h7F)));
            end
            6:
            begin
                // interrupt enables, fifo control, scratch
                rand_byte(b);
                wr(OFF_IER, b);
                rand_byte(b);
                wr(OFF_IIR, b);
                rd(OFF_IIR);
                rd(OFF_IER);
                rand_byte(b);
                wr(OFF_SCR, b);
                rd(OFF_SCR);
            end
            9:
            begin
                // overrun: more bytes than the ring holds
                wr(OFF_MCR, 8'($urandom_range(0, 255)) & ~{3'b000, MCR_LB});
                repeat ($urandom_range(RING_DEPTH + 1, RING_DEPTH + 4))
                begin
                    rand_byte(b);
                    line_byte(b);
                end
                rd(OFF_IIR);
                rd(OFF_LSR);
                rd(OFF_LSR);
                repeat ($urandom_range(0, RING_DEPTH)) rd(OFF_DATA);
            end
            default:
            begin
                // noise: any kind, the unused one now and then
                repeat ($urandom_range(1, 6))
                begin
                    rand_byte(b);
                    send_access(($urandom_range(0, 9) == 0) ? KIND_IDLE :
                                2'($urandom_range(0, 2)),
                                3'($urandom_range(0, 7)), b);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int random_start;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_READ;
        item_ch.reg_offset <= OFF_DATA;
        item_ch.wdata      <= 8'h00;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed: reset values, empty ring read, divisor latch extremes
        rd(OFF_IER);
        rd(OFF_IIR);
        rd(OFF_LSR);
        rd(OFF_DATA);
        wr(OFF_LCR, 8'hFF);
        rd(OFF_DATA);
        wr(OFF_DATA, 8'hFF);
        wr(OFF_IER, 8'h00);
        rd(OFF_IER);
        wr(OFF_LCR, 8'h03);
        // all enables, then loopback with every modem output set
        wr(OFF_IER, 8'hFF);
        wr(OFF_MCR, 8'hFF);
        rd(OFF_MSR);
        wr(OFF_DATA, 8'h00);
        rd(OFF_IIR);
        rd(OFF_DATA);
        // leaving loopback drops ri: trailing edge sets its delta
        wr(OFF_MCR, 8'h08);
        rd(OFF_MSR);
        wr(OFF_DATA, 8'hFF);
        rd(OFF_IIR);
        // fifo enable with ring clear, then a line byte
        wr(OFF_IIR, 8'h03);
        line_byte(8'hA5);
        // writes to the status registers are ignored
        wr(OFF_LSR, 8'hFF);
        wr(OFF_MSR, 8'hFF);
        wr(OFF_SCR, 8'hFF);
        rd(OFF_SCR);
        send_access(KIND_IDLE, OFF_SCR, 8'h5A);

        // random part
        random_start = sent_count;
        while (sent_count - random_start < RANDOM_BEATS)
        begin
            no_idle = (RANDOM_BEATS - (sent_count - random_start) < QUIET_TAIL) ||
                      ($urandom_range(0, 3) == 0);
            run_sequence($urandom_range(0, 9));
        end
        no_idle = 1'b1;
        item_ch.valid <= 1'b0;

        // drain, then allow for the input and result registers
        while (shadow.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
